### sv/assert_macros.svh
// assertion helpers for the rtl files, used by xpfec_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define XP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define XP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/xpfec_pkg.sv
package xpfec_pkg;

  localparam int FRAMES        = 1024;
  localparam int GROUP         = 2;
  localparam int PAYLOAD_WORDS = 20;

  localparam int KIND_W   = 8;
  localparam int SEQ_IN_W = 32;
  localparam int WI_W     = 5;
  localparam int WORD_W   = 64;
  localparam int SEQ_W    = $clog2(FRAMES);
  localparam int GI_W     = $clog2(GROUP);
  localparam int ADDR_W   = $clog2(FRAMES * PAYLOAD_WORDS);

  localparam logic [KIND_W-1:0] KIND_DATA   = 8'd0;
  localparam logic [KIND_W-1:0] KIND_PARITY = 8'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_EVAL, S_EMIT, S_GRP_RD, S_GRP_CHK, S_FWD,
    S_RB_P, S_RB_PD, S_RB_F, S_RB_FD, S_RB_WR, S_SETM, S_SETM_WR
  } state_e;

  // presence memory address source and write operation
  typedef enum logic [1:0] {PA_SEQ, PA_GRP, PA_MISS, PA_CLR} pres_sel_e;
  typedef enum logic [1:0] {PO_NONE, PO_CLR, PO_FRM, PO_PAR} pres_op_e;
  // frame and parity store address sources
  typedef enum logic [1:0] {FA_ITEM, FA_GRP, FA_MISS} fsel_e;
  typedef enum logic {PS_ITEM, PS_GRP} psel_e;

  typedef struct packed {
    logic      load_item;
    pres_sel_e pres_sel;
    pres_op_e  pres_op;
    logic      fst_wr;
    fsel_e     fsel;
    logic      pst_wr;
    psel_e     psel;
    logic      clr_step;
    logic      grp_init;
    logic      grp_acc;
    logic      i_clr;
    logic      rb_load_par;
    logic      rb_xor;
    logic      rb_write;
    logic      emit_item;
    logic      emit_lor;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_data;
    logic is_par;
    logic seq_ok;
    logic wi_ok;
    logic last;
    logic frm_bit;
    logic grp_ok;
    logic i_last;
    logic w_last;
    logic out_free;
  } sts_t;

  // word address of frame s, word w
  function automatic logic [ADDR_W-1:0] word_addr(logic [SEQ_W-1:0] s, logic [WI_W-1:0] w);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(s) * ADDR_W'(PAYLOAD_WORDS);
    return base + ADDR_W'(w);
  endfunction

endpackage

### sv/xor_parity_fec_receiver.sv
// a forwarded data word goes from the request registers through S_LOOK, S_EVAL and S_EMIT
// to the output register; the last word of a packet runs the group check and leaves from S_FWD
// a new word is taken only back in S_IDLE, once the last one is done; a rebuild reads the parity
// and frame stores anew for each payload word, as the stores are single-port
// reset: the 1024-entry presence memory is cleared one entry per cycle, and in_ready_o stays
// low until the clear is done; frame and parity stores are not cleared
module xor_parity_fec_receiver
  import xpfec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SEQ_IN_W-1:0] seq_i,
  input  logic [WI_W-1:0]     word_index_i,
  input  logic [WORD_W-1:0]   payload_word_i,
  input  logic                last_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SEQ_W-1:0]    out_seq_o,
  output logic [WI_W-1:0]     out_word_index_o,
  output logic [WORD_W-1:0]   out_word_o,
  output logic                out_recovered_o,
  output logic                last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  xpfec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xpfec_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .seq_i            (seq_i),
    .word_index_i     (word_index_i),
    .payload_word_i   (payload_word_i),
    .last_word_i      (last_word_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_seq_o        (out_seq_o),
    .out_word_index_o (out_word_index_o),
    .out_word_o       (out_word_o),
    .out_recovered_o  (out_recovered_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

### sv/xpfec_ram.sv
module xpfec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/xpfec_dp.sv
module xpfec_dp
  import xpfec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SEQ_IN_W-1:0] seq_i,
  input  logic [WI_W-1:0]     word_index_i,
  input  logic [WORD_W-1:0]   payload_word_i,
  input  logic                last_word_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SEQ_W-1:0]    out_seq_o,
  output logic [WI_W-1:0]     out_word_index_o,
  output logic [WORD_W-1:0]   out_word_o,
  output logic                out_recovered_o,
  output logic                last_of_run_o
);

  // request registers
  logic              is_data_q, is_par_q, seq_ok_q, last_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [WI_W-1:0]   wi_q;
  logic [WORD_W-1:0] word_q;

  // group and rebuild registers
  logic [SEQ_W:0]    clr_q, clr_d;
  logic [SEQ_W-1:0]  start_q, start_d, miss_q, miss_d;
  logic [GI_W-1:0]   gi_q, gi_d;
  logic [WI_W-1:0]   w_q, w_d;
  logic [1:0]        mcnt_q, mcnt_d;
  logic              par_seen_q, par_seen_d, bad_q, bad_d;
  logic [WORD_W-1:0] acc_q, acc_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [SEQ_W-1:0]  out_seq_q, out_seq_d;
  logic [WI_W-1:0]   out_wi_q, out_wi_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic              out_rec_q, out_rec_d, out_lor_q, out_lor_d;

  // memory ports
  logic [SEQ_W-1:0]  pres_addr;
  logic [1:0]        pres_wdata, pres_rdata;
  logic              pres_we;
  logic [ADDR_W-1:0] fst_addr, pst_addr;
  logic [WORD_W-1:0] fst_wdata, fst_rdata, pst_rdata;

  logic [SEQ_W:0]    grp_sum;
  logic [SEQ_W-1:0]  grp_s;

  assign grp_sum = {1'b0, start_q} + (SEQ_W + 1)'(gi_q);
  assign grp_s   = grp_sum[SEQ_W-1:0];

  // presence memory: bit 1 parity present, bit 0 frame present
  always_comb begin
    unique case (cmd_i.pres_sel)
      PA_SEQ:  pres_addr = seq_q;
      PA_GRP:  pres_addr = grp_s;
      PA_MISS: pres_addr = miss_q;
      PA_CLR:  pres_addr = clr_q[SEQ_W-1:0];
      default: pres_addr = seq_q;
    endcase
    pres_we = 1'b1;
    unique case (cmd_i.pres_op)
      PO_CLR:  pres_wdata = 2'b00;
      PO_FRM:  pres_wdata = pres_rdata | 2'b01;
      PO_PAR:  pres_wdata = pres_rdata | 2'b10;
      default: begin
        pres_wdata = pres_rdata;
        pres_we    = 1'b0;
      end
    endcase
  end

  // store addresses
  always_comb begin
    unique case (cmd_i.fsel)
      FA_ITEM: fst_addr = word_addr(seq_q, wi_q);
      FA_MISS: fst_addr = word_addr(miss_q, w_q);
      default: fst_addr = word_addr(grp_s, w_q);
    endcase
    fst_wdata = (cmd_i.fsel == FA_MISS) ? acc_q : word_q;
    pst_addr  = (cmd_i.psel == PS_GRP) ? word_addr(start_q, w_q) : word_addr(seq_q, wi_q);
  end

  xpfec_ram #(.WIDTH(2), .DEPTH(FRAMES)) u_pres (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .addr_i  (pres_addr),
    .wdata_i (pres_wdata),
    .rdata_o (pres_rdata)
  );

  xpfec_ram #(.WIDTH(WORD_W), .DEPTH(FRAMES * PAYLOAD_WORDS)) u_frames (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fst_wr),
    .addr_i  (fst_addr),
    .wdata_i (fst_wdata),
    .rdata_o (fst_rdata)
  );

  xpfec_ram #(.WIDTH(WORD_W), .DEPTH(FRAMES * PAYLOAD_WORDS)) u_parity (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pst_wr),
    .addr_i  (pst_addr),
    .wdata_i (word_q),
    .rdata_o (pst_rdata)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      is_data_q <= (kind_i == KIND_DATA);
      is_par_q  <= (kind_i == KIND_PARITY);
      seq_ok_q  <= (seq_i < SEQ_IN_W'(FRAMES));
      seq_q     <= seq_i[SEQ_W-1:0];
      wi_q      <= word_index_i;
      word_q    <= payload_word_i;
      last_q    <= last_word_i;
    end
  end

  // group check and rebuild bookkeeping
  always_comb begin
    clr_d      = clr_q;
    start_d    = start_q;
    miss_d     = miss_q;
    gi_d       = gi_q;
    w_d        = w_q;
    mcnt_d     = mcnt_q;
    par_seen_d = par_seen_q;
    bad_d      = bad_q;
    acc_d      = acc_q;
    if (cmd_i.clr_step) begin
      clr_d = clr_q + 1'b1;
    end
    if (cmd_i.grp_init) begin
      start_d    = is_data_q ? SEQ_W'((seq_q / GROUP) * GROUP) : seq_q;
      gi_d       = '0;
      w_d        = '0;
      mcnt_d     = '0;
      par_seen_d = 1'b0;
      bad_d      = 1'b0;
    end
    if (cmd_i.grp_acc) begin
      if (gi_q == '0) begin
        par_seen_d = pres_rdata[1];
      end
      if (grp_sum >= (SEQ_W + 1)'(FRAMES)) begin
        bad_d = 1'b1;
      end else if (!pres_rdata[0]) begin
        miss_d = grp_s;
        if (mcnt_q != 2'd2) begin
          mcnt_d = mcnt_q + 2'd1;
        end
      end
      gi_d = gi_q + 1'b1;
    end
    if (cmd_i.i_clr) begin
      gi_d = '0;
    end
    if (cmd_i.rb_load_par) begin
      acc_d = pst_rdata;
    end
    if (cmd_i.rb_xor) begin
      if (grp_s != miss_q) begin
        acc_d = acc_q ^ fst_rdata;
      end
      gi_d = gi_q + 1'b1;
    end
    if (cmd_i.rb_write) begin
      w_d = w_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    miss_q     <= miss_d;
    gi_q       <= gi_d;
    w_q        <= w_d;
    mcnt_q     <= mcnt_d;
    par_seen_q <= par_seen_d;
    bad_q      <= bad_d;
    acc_q      <= acc_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_seq_d   = out_seq_q;
    out_wi_d    = out_wi_q;
    out_word_d  = out_word_q;
    out_rec_d   = out_rec_q;
    out_lor_d   = out_lor_q;
    if (cmd_i.emit_item) begin
      out_valid_d = 1'b1;
      out_seq_d   = seq_q;
      out_wi_d    = wi_q;
      out_word_d  = word_q;
      out_rec_d   = 1'b0;
      out_lor_d   = cmd_i.emit_lor;
    end else if (cmd_i.rb_write) begin
      out_valid_d = 1'b1;
      out_seq_d   = miss_q;
      out_wi_d    = w_q;
      out_word_d  = acc_q;
      out_rec_d   = 1'b1;
      out_lor_d   = sts_o.w_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_seq_q  <= out_seq_d;
    out_wi_q   <= out_wi_d;
    out_word_q <= out_word_d;
    out_rec_q  <= out_rec_d;
    out_lor_q  <= out_lor_d;
  end

  // status to the controller
  always_comb begin
    sts_o.clr_done = (clr_q == (SEQ_W + 1)'(FRAMES));
    sts_o.is_data  = is_data_q;
    sts_o.is_par   = is_par_q;
    sts_o.seq_ok   = seq_ok_q;
    sts_o.wi_ok    = (wi_q < WI_W'(PAYLOAD_WORDS));
    sts_o.last     = last_q;
    sts_o.frm_bit  = pres_rdata[0];
    sts_o.grp_ok   = par_seen_q & ~bad_q & (mcnt_q == 2'd1);
    sts_o.i_last   = (gi_q == GI_W'(GROUP - 1));
    sts_o.w_last   = (w_q == WI_W'(PAYLOAD_WORDS - 1));
    sts_o.out_free = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_seq_o        = out_seq_q;
  assign out_word_index_o = out_wi_q;
  assign out_word_o       = out_word_q;
  assign out_recovered_o  = out_rec_q;
  assign last_of_run_o    = out_lor_q;

endmodule

### sv/xpfec_ctrl.sv
`include "assert_macros.svh"

module xpfec_ctrl
  import xpfec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.pres_sel = PA_SEQ;
    cmd_o.pres_op  = PO_NONE;
    cmd_o.fsel     = FA_GRP;
    cmd_o.psel     = PS_ITEM;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.pres_sel = PA_CLR;
          cmd_o.pres_op  = PO_CLR;
          cmd_o.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (sts_i.seq_ok && sts_i.is_data && !sts_i.frm_bit) begin
          cmd_o.fst_wr = sts_i.wi_ok;
          cmd_o.fsel   = FA_ITEM;
          if (sts_i.last) begin
            cmd_o.pres_op  = PO_FRM;
            cmd_o.grp_init = 1'b1;
            state_d = S_GRP_RD;
          end else if (sts_i.wi_ok) begin
            state_d = S_EMIT;
          end
        end else if (sts_i.seq_ok && sts_i.is_par) begin
          cmd_o.pst_wr = sts_i.wi_ok;
          if (sts_i.last) begin
            cmd_o.pres_op  = PO_PAR;
            cmd_o.grp_init = 1'b1;
            state_d = S_GRP_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_item = 1'b1;
          cmd_o.emit_lor  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_GRP_RD: begin
        cmd_o.pres_sel = PA_GRP;
        state_d = S_GRP_CHK;
      end
      S_GRP_CHK: begin
        cmd_o.grp_acc = 1'b1;
        state_d = sts_i.i_last ? S_FWD : S_GRP_RD;
      end
      S_FWD: begin
        if (sts_i.is_data && sts_i.wi_ok) begin
          if (sts_i.out_free) begin
            cmd_o.emit_item = 1'b1;
            cmd_o.emit_lor  = ~sts_i.grp_ok;
            state_d = sts_i.grp_ok ? S_RB_P : S_IDLE;
          end
        end else begin
          state_d = sts_i.grp_ok ? S_RB_P : S_IDLE;
        end
      end
      S_RB_P: begin
        cmd_o.psel  = PS_GRP;
        cmd_o.i_clr = 1'b1;
        state_d = S_RB_PD;
      end
      S_RB_PD: begin
        cmd_o.rb_load_par = 1'b1;
        state_d = S_RB_F;
      end
      S_RB_F: begin
        state_d = S_RB_FD;
      end
      S_RB_FD: begin
        cmd_o.rb_xor = 1'b1;
        state_d = sts_i.i_last ? S_RB_WR : S_RB_F;
      end
      S_RB_WR: begin
        if (sts_i.out_free) begin
          cmd_o.fst_wr   = 1'b1;
          cmd_o.fsel     = FA_MISS;
          cmd_o.rb_write = 1'b1;
          state_d = sts_i.w_last ? S_SETM : S_RB_P;
        end
      end
      S_SETM: begin
        cmd_o.pres_sel = PA_MISS;
        state_d = S_SETM_WR;
      end
      S_SETM_WR: begin
        cmd_o.pres_sel = PA_MISS;
        cmd_o.pres_op  = PO_FRM;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // results only go into a free output register
  `XP_ASSERT(a_emit_free, (cmd_o.emit_item || cmd_o.rb_write) |-> sts_i.out_free, "emit into busy output")
  // rebuilt words only for a group that qualified
  `XP_ASSERT(a_rb_grp_ok, cmd_o.rb_write |-> sts_i.grp_ok, "rebuild without a qualified group")
  // no request taken while the presence memory is being cleared
  `XP_ASSERT_ALWAYS(a_clear_block, (state_q == S_CLEAR) |-> !in_ready_o, "request taken during clear")

endmodule

### tb/xpfec_checker.sv
`timescale 1ns / 100ps

// watches both channels, predicts the recovered stream and compares
module xpfec_checker
  import xpfec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SEQ_IN_W-1:0] seq_i,
  input  logic [WI_W-1:0]     word_index_i,
  input  logic [WORD_W-1:0]   payload_word_i,
  input  logic                last_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [SEQ_W-1:0]    out_seq_i,
  input  logic [WI_W-1:0]     out_word_index_i,
  input  logic [WORD_W-1:0]   out_word_i,
  input  logic                out_recovered_i,
  input  logic                last_of_run_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [SEQ_W-1:0]  fseq;
    logic [WI_W-1:0]   widx;
    logic [WORD_W-1:0] word;
    logic              rec;
    logic              lor;
  } frame_word_t;

  // shadow copy of the receiver state
  logic [WORD_W-1:0] frame_mem [FRAMES*PAYLOAD_WORDS];
  logic [WORD_W-1:0] parity_mem[FRAMES*PAYLOAD_WORDS];
  bit                have_frame [FRAMES];
  bit                have_parity[FRAMES];
  bit                dropping;

  frame_word_t expected_words[$];
  int          fails = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = expected_words.size();

  // rebuild the single missing frame of the group at start, if possible
  task automatic try_rebuild(input int start, inout frame_word_t run[$]);
    int missing;
    int miss;
    logic [WORD_W-1:0] acc;
    missing = 0;
    miss    = 0;
    if (start >= FRAMES || !have_parity[start]) return;
    for (int i = 0; i < GROUP; i++) begin
      if (start + i >= FRAMES) return;
      if (!have_frame[start+i]) begin
        missing++;
        miss = start + i;
      end
    end
    if (missing != 1) return;
    for (int w = 0; w < PAYLOAD_WORDS; w++) begin
      acc = parity_mem[start*PAYLOAD_WORDS + w];
      for (int i = 0; i < GROUP; i++)
        if (start + i != miss) acc ^= frame_mem[(start+i)*PAYLOAD_WORDS + w];
      frame_mem[miss*PAYLOAD_WORDS + w] = acc;
      run.push_back('{SEQ_W'(miss), WI_W'(w), acc, 1'b1, 1'b0});
    end
    have_frame[miss] = 1'b1;
  endtask

  // work out the results of one accepted request
  task automatic apply_request();
    frame_word_t run[$];
    int s;
    bit wi_ok;
    wi_ok = word_index_i < PAYLOAD_WORDS;
    if (kind_i != KIND_DATA && kind_i != KIND_PARITY) return;
    if (seq_i >= FRAMES) begin
      if (kind_i == KIND_DATA) dropping = !last_word_i;
      return;
    end
    s = int'(seq_i);
    if (kind_i == KIND_DATA) begin
      if (have_frame[s]) begin
        dropping = !last_word_i;
        return;
      end
      dropping = 1'b0;
      if (wi_ok) begin
        frame_mem[s*PAYLOAD_WORDS + word_index_i] = payload_word_i;
        run.push_back('{SEQ_W'(s), word_index_i, payload_word_i, 1'b0, 1'b0});
      end
      if (last_word_i) begin
        have_frame[s] = 1'b1;
        try_rebuild((s / GROUP) * GROUP, run);
      end
    end else begin
      if (wi_ok) parity_mem[s*PAYLOAD_WORDS + word_index_i] = payload_word_i;
      if (last_word_i) begin
        have_parity[s] = 1'b1;
        try_rebuild(s, run);
      end
    end
    if (run.size() > 0) run[run.size()-1].lor = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endtask

  // compare outputs first, then predict from the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t exp_w;
    if (!rst_ni) begin
      foreach (have_frame[i]) have_frame[i] = 1'b0;
      foreach (have_parity[i]) have_parity[i] = 1'b0;
      dropping = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected output: seq %0d idx %0d word %h rec %b lor %b",
                     out_seq_i, out_word_index_i, out_word_i, out_recovered_i,
                     last_of_run_i);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.fseq !== out_seq_i || exp_w.widx !== out_word_index_i ||
              exp_w.word !== out_word_i || exp_w.rec !== out_recovered_i ||
              exp_w.lor !== last_of_run_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp seq %0d idx %0d word %h rec %b lor %b",
                       exp_w.fseq, exp_w.widx, exp_w.word, exp_w.rec, exp_w.lor,
                       " / got seq %0d idx %0d word %h rec %b lor %b",
                       out_seq_i, out_word_index_i, out_word_i, out_recovered_i,
                       last_of_run_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_request();
    end
  end

endmodule

### tb/tb_xor_parity_fec_receiver.sv
`timescale 1ns / 100ps

module tb_xor_parity_fec_receiver;
  import xpfec_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic [SEQ_IN_W-1:0] seq_i;
  logic [WI_W-1:0]     word_index_i;
  logic [WORD_W-1:0]   payload_word_i;
  logic                last_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SEQ_W-1:0]    out_seq_o;
  logic [WI_W-1:0]     out_word_index_o;
  logic [WORD_W-1:0]   out_word_o;
  logic                out_recovered_o;
  logic                last_of_run_o;

  int  fail_cnt;
  int  pending;
  int  sent_words = 0;
  int  phase      = 0;
  bit  hold_done  = 0;

  xor_parity_fec_receiver dut (.*);

  xpfec_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .seq_i, .word_index_i,
    .payload_word_i, .last_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_seq_i(out_seq_o),
    .out_word_index_i(out_word_index_o), .out_word_i(out_word_o),
    .out_recovered_i(out_recovered_o), .last_of_run_i(last_of_run_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver side: random stalls per phase, one long hold-off early on
  initial begin
    int pct;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_words >= 40) begin
        hold_done = 1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      pct = (phase == 0) ? 87 : (phase == 1) ? 36 : 0;
      out_ready_i <= ($urandom_range(99) >= pct);
    end
  end

  // offer one request and wait until it is taken
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SEQ_IN_W-1:0] seq,
                           input logic [WI_W-1:0] widx, input logic last);
    int pct;
    pct = (phase == 0) ? 36 : (phase == 1) ? 87 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    seq_i          <= seq;
    word_index_i   <= widx;
    payload_word_i <= {$urandom, $urandom};
    last_word_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent_words++;
    phase = (sent_words < 110) ? 0 : (sent_words < 220) ? 1 : 2;
  endtask

  // whole or partial packet, sometimes with a stray out-of-range index word
  task automatic send_packet(input logic [KIND_W-1:0] kind, input int seq, input int nw,
                             input bit with_last);
    int bad_at;
    bad_at = ($urandom_range(3) == 0) ? $urandom_range(nw - 1) : -1;
    for (int w = 0; w < nw; w++) begin
      if (w == bad_at)
        send_word(kind, seq, WI_W'($urandom_range(31, PAYLOAD_WORDS)), 1'b0);
      send_word(kind, seq, WI_W'(w), with_last && (w == nw - 1));
    end
  endtask

  // ignored or dropped single words
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_word(KIND_W'($urandom_range(255, 2)), $urandom, WI_W'($urandom),
                   1'($urandom));
      1: send_word(KIND_DATA, $urandom_range(32'hFFFF_FFFF, FRAMES), WI_W'($urandom),
                   1'($urandom));
      default: send_word(KIND_PARITY, $urandom_range(32'hFFFF_FFFF, FRAMES),
                         WI_W'($urandom), 1'($urandom));
    endcase
  endtask

  // stimulus and verdict
  initial begin
    int grp;
    int lost;
    int kept;
    in_valid_i     <= 1'b0;
    kind_i         <= '0;
    seq_i          <= '0;
    word_index_i   <= '0;
    payload_word_i <= '0;
    last_word_i    <= 1'b0;
    rst_ni          = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unknown kinds, out-of-range sequences, group past the end
    send_word(8'hFF, 32'hFFFF_FFFF, 5'd31, 1'b1);
    send_word(8'd2, 32'd0, 5'd0, 1'b0);
    send_word(KIND_DATA, 32'hFFFF_FFFF, 5'd0, 1'b0);
    send_word(KIND_DATA, FRAMES, 5'd19, 1'b1);
    send_word(KIND_PARITY, 32'h8000_0000, 5'd3, 1'b1);
    send_packet(KIND_PARITY, FRAMES - 1, PAYLOAD_WORDS, 1'b1);

    // random groups: recovery, partial frames, duplicates, no parity
    grp = 0;
    while (sent_words < 330 && grp < FRAMES - 2) begin
      lost = grp + $urandom_range(1);
      kept = (lost == grp) ? grp + 1 : grp;
      case ($urandom_range(3))
        0: begin
          if ($urandom_range(1)) begin
            send_packet(KIND_PARITY, grp, PAYLOAD_WORDS, 1'b1);
            send_packet(KIND_DATA, kept, PAYLOAD_WORDS, 1'b1);
          end else begin
            send_packet(KIND_DATA, kept, PAYLOAD_WORDS, 1'b1);
            send_packet(KIND_PARITY, grp, PAYLOAD_WORDS, 1'b1);
          end
          send_packet(KIND_DATA, lost, $urandom_range(PAYLOAD_WORDS, 1), 1'b1);
        end
        1: begin
          send_packet(KIND_DATA, lost, $urandom_range(PAYLOAD_WORDS - 1, 1), 1'b0);
          send_packet(KIND_DATA, kept, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_PARITY, grp, PAYLOAD_WORDS, 1'b1);
        end
        2: begin
          send_packet(KIND_DATA, kept, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_DATA, lost, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_PARITY, grp, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_DATA, kept, $urandom_range(PAYLOAD_WORDS, 1), 1'b1);
        end
        default: begin
          send_packet(KIND_DATA, lost, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_DATA, kept, PAYLOAD_WORDS, 1'b1);
          send_packet(KIND_DATA, lost, $urandom_range(PAYLOAD_WORDS, 1), 1'b1);
        end
      endcase
      repeat ($urandom_range(3)) send_noise();
      grp += GROUP * $urandom_range(40, 1);
    end
    in_valid_i <= 1'b0;

    // drain, then let the block settle
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
